// ===== rtl/iol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic               wr_en;
    logic [CMP_W-1:0]   pos;
    logic [CMP_W-1:0]   count;
    logic [ELEM_W-1:0]  elem;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/iol_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iol_cell (
  input  wire logic                       clk,
  input  wire logic [iol_pkg::IDX_W-1:0]  idx,
  input  wire iol_pkg::cell_ctl_t         ctl,
  input  wire logic [iol_pkg::ELEM_W-1:0] prev_word,
  input  wire logic [iol_pkg::ELEM_W-1:0] next_word,
  output      logic [iol_pkg::ELEM_W-1:0] word,
  output      logic                       hit,
  output      logic                       sel
);
  import iol_pkg::*;

  logic [CMP_W-1:0] my_pos;

  assign my_pos = CMP_W'(idx);
  assign sel    = (my_pos == ctl.pos);
  assign hit    = (word == ctl.elem) && (my_pos < ctl.count);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (my_pos > ctl.pos) begin
        word <= prev_word;
      end else if (sel) begin
        word <= ctl.elem;
      end
    end else if (ctl.rem_en) begin
      if (my_pos >= ctl.pos) begin
        word <= next_word;
      end
    end else if (ctl.wr_en && sel) begin
      word <= ctl.elem;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iol_first_hit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iol_first_hit (
  input  wire logic [iol_pkg::CAPACITY-1:0] hits,
  output      logic                         found,
  output      logic [iol_pkg::IDX_W-1:0]    index
);
  import iol_pkg::*;

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        found = 1'b1;
        index = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/indexed_ordered_list.sv =====
// Indexed ordered list held in a row of shift cells.
// Request channel: in_valid/in_ready with command, position, element.
// Result channel: out_valid/out_ready with status, data, found,
// found_position, count, empty_res; one result per request.
// When a request is taken, all cells shift, overwrite or compare
// together at that edge, and the read word and count are captured. The
// next cycle priority-encodes the captured match vector in the 64-input
// first-hit encoder, which picks the lowest index, and raises out_valid.
// out_valid is raised from the busy state at the edge after the request edge.
// A new request is not taken until the last result has been taken;
// in_ready is low while a request is in flight or a result waits.
// When the receiver stalls the result is held and no request is taken.
// Reset clears the count and handshake state; cell words are not reset,
// positions at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module indexed_ordered_list (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [6:0]  position,
  input  wire logic [31:0] element,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  status,
  output      logic [31:0] data,
  output      logic        found,
  output      logic [5:0]  found_position,
  output      logic [6:0]  count,
  output      logic        empty_res
);
  import iol_pkg::*;

  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    entry_count_next;
  logic                busy;
  logic                is_find;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] sels;
  logic [ELEM_W-1:0]   words [CAPACITY];
  logic [ELEM_W-1:0]   sel_word;
  logic                enc_found;
  logic [IDX_W-1:0]    enc_index;
  logic                take;
  cell_ctl_t           ctl;
  status_t             st_next;
  logic [ELEM_W-1:0]   data_next;
  logic [CMP_W-1:0]    pos_w;
  logic [CMP_W-1:0]    cnt_w;
  logic                full;
  logic                rd_ok;

  assign in_ready = !busy && !out_valid;
  assign take     = in_valid && in_ready;
  assign pos_w    = CMP_W'(position);
  assign cnt_w    = CMP_W'(entry_count);
  assign full     = (entry_count >= CNT_W'(CAPACITY));
  assign rd_ok    = (pos_w < cnt_w);

  always_comb begin
    ctl              = '0;
    ctl.pos          = pos_w;
    ctl.count        = cnt_w;
    ctl.elem         = ELEM_W'(element);
    st_next          = ST_OK;
    data_next        = '0;
    entry_count_next = entry_count;
    unique case (cmd_t'(command))
      CMD_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else if (pos_w > cnt_w) begin
          st_next = ST_RANGE;
        end else begin
          ctl.ins_en       = take;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (!rd_ok) begin
          st_next = ST_RANGE;
        end else begin
          ctl.rem_en       = take;
          data_next        = sel_word;
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (!rd_ok) begin
          st_next = ST_RANGE;
        end else begin
          data_next = sel_word;
        end
      end
      CMD_WRITE: begin
        if (!rd_ok) begin
          st_next = ST_RANGE;
        end else begin
          ctl.wr_en = take;
        end
      end
      CMD_CLEAR: entry_count_next = '0;
      default: ;
    endcase
  end

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | (words[i] & {ELEM_W{sels[i]}});
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_W-1:0] prev_w;
    logic [ELEM_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = ctl.elem;
    end else begin : g_mid
      assign prev_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = words[g];
    end else begin : g_inner
      assign next_w = words[g+1];
    end
    iol_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .ctl       (ctl),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (words[g]),
      .hit       (hits[g]),
      .sel       (sels[g])
    );
  end

  iol_first_hit u_first_hit (
    .hits  (hit_vec),
    .found (enc_found),
    .index (enc_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      busy        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        entry_count    <= entry_count_next;
        busy           <= 1'b1;
        is_find        <= (cmd_t'(command) == CMD_FIND);
        hit_vec        <= hits;
        status         <= st_next;
        data           <= 32'(data_next);
        count          <= 7'(entry_count_next);
        empty_res      <= (entry_count_next == '0);
      end else if (busy) begin
        busy           <= 1'b0;
        out_valid      <= 1'b1;
        found          <= is_find && enc_found;
        found_position <= (is_find && enc_found) ? 6'(enc_index) : 6'd0;
      end else if (out_valid && out_ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
